// File: hw/rtl/twi_pkg.sv
// ----------------------------------------------------------------------------
// twi_pkg: shared types and constants of the waypoint interpolator
// Register indexes, operation codes and the queued sample request format.
// ----------------------------------------------------------------------------
package twi_pkg;

    localparam logic [1:0] REG_STEP_TICKS   = 2'd0;
    localparam logic [1:0] REG_NODE_COUNT   = 2'd1;
    localparam logic [1:0] REG_TARGET_COUNT = 2'd2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam int TDATA_IN_W  = 112;  // node_index,x_in,y_in,sim_time
    localparam int TDATA_OUT_W = 128;  // x_pos,y_pos,x_vel,y_vel

    // Sample request passed from the front end to the back end
    typedef struct packed {
        logic        valid_res;  // target in range and nodes exist
        logic        single;     // one node only
        logic [3:0]  target;
        logic [31:0] sim_time;
    } twi_req_t;

endpackage

// File: hw/rtl/twi_front.sv
// ----------------------------------------------------------------------------
// twi_front: input classification
// Accepts input transfers, routes loads to the store, queues sample requests.
// ----------------------------------------------------------------------------
module twi_front #(
    parameter int MAX_TARGETS = 16,
    parameter int MAX_NODES   = 256
) (
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_op,
    input  logic [3:0]            in_target,
    input  logic [7:0]            in_node,
    input  logic [8:0]            node_count,
    input  logic [4:0]            target_count,
    input  logic [31:0]           in_time,
    input  logic                  load_hold,
    output logic                  wr_en,
    output twi_pkg::twi_req_t     req,
    output logic                  req_valid,
    input  logic                  req_ready
);
    import twi_pkg::*;

    logic accept;
    logic tgt_ok;

    // Check the target against both the register and the store size, and that nodes exist
    assign tgt_ok = ({1'b0, in_target} < target_count) &&
                    (32'(in_target) < 32'(MAX_TARGETS)) &&
                    (node_count != 9'd0);

    // Hold loads while a sample still has to read the store; samples need room
    assign in_ready = (in_op == OP_LOAD) ? !load_hold : req_ready;
    assign accept   = in_valid && in_ready;
    assign wr_en    = accept && (in_op == OP_LOAD) &&
                      (32'(in_target) < 32'(MAX_TARGETS)) &&
                      (32'(in_node) < 32'(MAX_NODES));

    assign req_valid     = accept && (in_op == OP_SAMPLE);
    assign req.valid_res = tgt_ok;
    assign req.single    = (node_count == 9'd1);
    assign req.target    = in_target;
    assign req.sim_time  = in_time;

endmodule

// File: hw/rtl/twi_queue.sv
// ----------------------------------------------------------------------------
// twi_queue: two-entry request queue
// Decouples sample classification from the interpolation back end.
// ----------------------------------------------------------------------------
module twi_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              has_room,
    input  twi_pkg::twi_req_t din,
    output logic              pop_valid,
    input  logic              pop,
    output twi_pkg::twi_req_t dout
);
    import twi_pkg::*;

    twi_req_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign has_room  = (cnt_reg != 2'd2);
    assign pop_valid = (cnt_reg != 2'd0);
    assign dout      = mem_reg[rp_reg];

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= din;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) (cnt_reg == 2'd2) |-> !push)
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) (cnt_reg == 2'd0) |-> !pop)
        else $error("queue underflow");
    assert property (@(posedge clk) disable iff (!rst_n) (push && !pop) |=> (cnt_reg != 2'd0))
        else $error("queue count lost push");

endmodule

// File: hw/rtl/twi_div.sv
// ----------------------------------------------------------------------------
// twi_div: radix-2 restoring divider
// Unsigned 48/16 divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twi_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [47:0] quot,
    output logic [15:0] rem
);
    logic [47:0] q_reg;
    logic [16:0] r_reg;
    logic [15:0] d_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [16:0] trial;
    logic [16:0] sh;

    assign sh    = {r_reg[15:0], q_reg[47]};
    assign trial = sh - {1'b0, d_reg};
    assign quot  = q_reg;
    assign rem   = r_reg[15:0];
    assign done  = busy_reg && (cnt_reg == 6'd0);

    // Shift in one dividend bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            q_reg    <= '0;
            r_reg    <= '0;
            d_reg    <= 16'd1;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 6'd48;
            q_reg    <= dividend;
            r_reg    <= '0;
            d_reg    <= divisor;
        end
        else if (busy_reg && cnt_reg != 6'd0)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (!trial[16])
            begin
                r_reg <= trial;
                q_reg <= {q_reg[46:0], 1'b1};
            end
            else
            begin
                r_reg <= sh;
                q_reg <= {q_reg[46:0], 1'b0};
            end
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
    end

endmodule

// File: hw/rtl/twi_back.sv
// ----------------------------------------------------------------------------
// twi_back: interpolation back end
// Divides time, reads two waypoints, interpolates and holds the result.
// ----------------------------------------------------------------------------
module twi_back #(
    parameter int MAX_TARGETS = 16,
    parameter int MAX_NODES   = 256,
    parameter int COORD_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [3:0]             wr_target,
    input  logic [7:0]             wr_node,
    input  logic [31:0]            wr_x,
    input  logic [31:0]            wr_y,
    input  logic [15:0]            step_ticks,
    input  logic [8:0]             node_count,
    input  logic                   req_valid,
    output logic                   req_pop,
    input  twi_pkg::twi_req_t      req,
    output logic                   busy,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [127:0]           out_data,
    output logic                   out_valid_res
);
    import twi_pkg::*;

    localparam int TW    = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int NW    = $clog2(MAX_NODES);
    localparam int AW    = TW + NW;
    localparam int DEPTH = MAX_TARGETS * (1 << NW);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV1, S_DIV2, S_RDA, S_RDB, S_WAITB, S_MUL, S_VEL, S_SUM, S_OUT
    } state_t;

    state_t       state_reg;
    logic [63:0]  mem [DEPTH];
    logic [63:0]  rd_reg;
    logic [AW-1:0] rd_addr;
    logic         rd_en;

    twi_req_t     cur_reg;
    logic [15:0]  step_reg;
    logic [8:0]   n_reg;
    logic [NW-1:0] idx_reg, nxt_reg;
    logic [31:0]  qs_reg;
    logic [5:0]   mcnt_reg;
    logic [15:0]  frac_reg;
    logic signed [32:0] ax_reg, ay_reg, dx_reg, dy_reg;
    logic signed [49:0] px_reg, py_reg;
    logic [31:0]  xp_reg, yp_reg, xv_reg, yv_reg;
    logic         vr_reg;
    logic         ov_reg;

    // divider shared by the four divisions of one sample
    logic         dv_start;
    logic [47:0]  dv_dvd, dv_q;
    logic [15:0]  dv_r;
    logic         dv_done;
    logic [1:0]   vphase_reg;
    logic         kick;

    twi_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (dv_start),
        .dividend(dv_dvd),
        .divisor (step_reg),
        .done    (dv_done),
        .quot    (dv_q),
        .rem     (dv_r)
    );

    function automatic logic signed [32:0] sext(input logic [31:0] v);
        logic [COORD_WIDTH-1:0] c;
        c = v[COORD_WIDTH-1:0];
        return 33'(signed'(c));
    endfunction

    function automatic logic [31:0] sat(input logic signed [49:0] v);
        logic signed [49:0] hi, lo;
        hi = 50'sd1 <<< (COORD_WIDTH - 1);
        lo = -hi;
        hi = hi - 50'sd1;
        if (v > hi) return 32'(hi);
        if (v < lo) return 32'(lo);
        return 32'(v);
    endfunction

    // magnitude of a signed value, and signed truncating quotient
    logic signed [32:0] vsel;
    logic [47:0] vmag;
    assign vsel   = (vphase_reg == 2'd1) ? dx_reg : dy_reg;
    assign vmag   = 48'(vsel[32] ? -vsel : vsel);

    // start the divider for the fraction and both velocities
    assign kick = ((state_reg == S_DIV2) || (state_reg == S_VEL)) && !ov_reg;

    always_comb
    begin
        dv_start = kick;
        dv_dvd   = 48'(cur_reg.sim_time);
        case (state_reg)
            S_DIV1:  dv_start = !dv_done && !ov_reg;
            S_DIV2:  dv_dvd   = {16'd0, dv_r, 16'd0};
            S_VEL:   dv_dvd   = vmag;
            default: dv_dvd   = 48'(cur_reg.sim_time);
        endcase
    end

    // waypoint memory
    assign rd_en   = (state_reg == S_RDA) || (state_reg == S_RDB);
    assign rd_addr = (state_reg == S_RDA) ? {TW'(cur_reg.target), idx_reg}
                                          : {TW'(cur_reg.target), nxt_reg};
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[{TW'(wr_target), NW'(wr_node)}] <=
                {32'(sext(wr_y)), 32'(sext(wr_x))};
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    assign req_pop       = (state_reg == S_IDLE) && req_valid && !out_valid;
    assign busy          = (state_reg != S_IDLE) && (state_reg != S_OUT);
    assign out_valid     = (state_reg == S_OUT);
    assign out_data      = {yv_reg, xv_reg, yp_reg, xp_reg};
    assign out_valid_res = vr_reg;

    // one step of the node index reduction, one quotient bit at a time
    logic [NW:0] mwide, mred;
    logic [8:0]  nx;
    assign mwide = {idx_reg, qs_reg[31]};
    assign mred  = (mwide >= (NW+1)'(n_reg)) ? mwide - (NW+1)'(n_reg) : mwide;
    assign nx    = 9'(idx_reg) + 9'd1;

    // sequence one sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            vphase_reg <= 2'd0;
            ov_reg     <= 1'b0;
            vr_reg     <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req_pop)
                    begin
                        cur_reg  <= req;
                        step_reg <= (step_ticks == 16'd0) ? 16'd1 : step_ticks;
                        n_reg    <= (32'(node_count) > 32'(MAX_NODES)) ? 9'(MAX_NODES)
                                                                       : node_count;
                        vphase_reg <= 2'd0;
                        ov_reg   <= 1'b0;
                        if (!req.valid_res)
                        begin
                            {xp_reg, yp_reg, xv_reg, yv_reg} <= '0;
                            vr_reg    <= 1'b0;
                            state_reg <= S_OUT;
                        end
                        else if (req.single)
                        begin
                            idx_reg   <= '0;
                            nxt_reg   <= '0;
                            state_reg <= S_RDA;
                        end
                        else
                            state_reg <= S_DIV1;
                    end
                end
                S_DIV1:
                begin
                    if (dv_done && ov_reg)
                    begin
                        // hand the tick quotient to the node index reduction
                        qs_reg    <= dv_q[31:0];
                        idx_reg   <= '0;
                        mcnt_reg  <= 6'd32;
                        ov_reg    <= 1'b0;
                        state_reg <= S_DIV2;
                    end
                    else
                        ov_reg <= 1'b1;
                end
                S_DIV2:
                begin
                    // quotient mod n, one bit per step, beside the fraction divide
                    if (!ov_reg)
                        ov_reg <= 1'b1;
                    if (mcnt_reg != 6'd0)
                    begin
                        idx_reg  <= NW'(mred);
                        qs_reg   <= {qs_reg[30:0], 1'b0};
                        mcnt_reg <= mcnt_reg - 6'd1;
                    end
                    else if (ov_reg && dv_done)
                    begin
                        frac_reg  <= dv_q[15:0];
                        nxt_reg   <= (nx == n_reg) ? '0 : NW'(nx);
                        ov_reg    <= 1'b0;
                        state_reg <= S_RDA;
                    end
                end
                S_RDA: state_reg <= S_RDB;
                S_RDB:
                begin
                    ax_reg    <= sext(rd_reg[31:0]);
                    ay_reg    <= sext(rd_reg[63:32]);
                    state_reg <= S_WAITB;
                end
                S_WAITB:
                begin
                    dx_reg <= sext(rd_reg[31:0]) - ax_reg;
                    dy_reg <= sext(rd_reg[63:32]) - ay_reg;
                    if (cur_reg.single)
                    begin
                        xp_reg <= 32'(ax_reg);
                        yp_reg <= 32'(ay_reg);
                        xv_reg <= '0;
                        yv_reg <= '0;
                        vr_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                        state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    px_reg <= dx_reg * $signed({1'b0, frac_reg});
                    py_reg <= dy_reg * $signed({1'b0, frac_reg});
                    vphase_reg <= 2'd1;
                    ov_reg <= 1'b0;
                    state_reg <= S_VEL;
                end
                S_VEL:
                begin
                    if (!ov_reg)
                        ov_reg <= 1'b1;
                    else if (dv_done)
                    begin
                        if (vphase_reg == 2'd1)
                        begin
                            xv_reg <= sat(dx_reg[32] ? -50'(dv_q) : 50'(dv_q));
                            vphase_reg <= 2'd2;
                            ov_reg <= 1'b0;
                        end
                        else
                        begin
                            yv_reg <= sat(dy_reg[32] ? -50'(dv_q) : 50'(dv_q));
                            state_reg <= S_SUM;
                        end
                    end
                end
                S_SUM:
                begin
                    xp_reg <= sat(50'(ax_reg) + ((px_reg + ((px_reg < 0) ? 50'sd65535 : 50'sd0))
                              >>> 16));
                    yp_reg <= sat(50'(ay_reg) + ((py_reg + ((py_reg < 0) ? 50'sd65535 : 50'sd0))
                              >>> 16));
                    vr_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n) req_pop |-> !out_valid)
        else $error("pop while busy");
    assert property (@(posedge clk) disable iff (!rst_n) busy |-> !wr_en)
        else $error("load during sample read");

endmodule

// File: hw/rtl/trajectory_waypoint_interpolator.sv
// ----------------------------------------------------------------------------
// trajectory_waypoint_interpolator: periodic waypoint interpolation
// Loads waypoints per target and samples position and velocity at a time.
// ----------------------------------------------------------------------------
// Sequence: a load is written at its transfer; a sample result follows four divides
// on the shared divider (tick quotient, fraction, two velocities); a single node
// skips the divides and an invalid sample goes straight to the output.
// Throughput: one load per cycle while no sample is queued or in the back end; a
// new sample starts only after the last result is taken, with two more queued ahead.
// Reset: asynchronous active low; step 1, counts 0; waypoint memory undefined.
module trajectory_waypoint_interpolator #(
    parameter int MAX_TARGETS = 16,
    parameter int MAX_NODES   = 256,
    parameter int COORD_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [twi_pkg::TDATA_IN_W-1:0]  s_axis_tdata,  // node_index, x_in, y_in, sim_time
    input  logic [4:0]   s_axis_tuser,   // operation, target_index
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [twi_pkg::TDATA_OUT_W-1:0] m_axis_tdata,  // x_pos, y_pos, x_vel, y_vel
    output logic         m_axis_tuser,   // valid_res
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    import twi_pkg::*;

    logic [15:0] step_reg;
    logic [8:0]  nodes_reg;
    logic [4:0]  targets_reg;
    logic        wr_en, req_valid, room, qv, pop;
    logic        back_busy, load_hold;
    twi_req_t    req, qout;

    assign cfg_ready = 1'b1;

    // Hold loads while any sample is queued or still reading the store
    assign load_hold = qv || back_busy;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= 16'd1;
            nodes_reg   <= 9'd0;
            targets_reg <= 5'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_STEP_TICKS:   step_reg    <= cfg_data;
                REG_NODE_COUNT:   nodes_reg   <= cfg_data[8:0];
                REG_TARGET_COUNT: targets_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    twi_front #(.MAX_TARGETS(MAX_TARGETS), .MAX_NODES(MAX_NODES)) u_front (
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_op(s_axis_tuser[0]), .in_target(s_axis_tuser[4:1]),
        .in_node(s_axis_tdata[7:0]),
        .node_count(nodes_reg), .target_count(targets_reg),
        .in_time(s_axis_tdata[103:72]), .load_hold(load_hold),
        .wr_en(wr_en), .req(req), .req_valid(req_valid), .req_ready(room)
    );

    twi_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(req_valid), .has_room(room),
        .din(req), .pop_valid(qv), .pop(pop), .dout(qout)
    );

    twi_back #(.MAX_TARGETS(MAX_TARGETS), .MAX_NODES(MAX_NODES),
               .COORD_WIDTH(COORD_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_target(s_axis_tuser[4:1]), .wr_node(s_axis_tdata[7:0]),
        .wr_x(s_axis_tdata[39:8]), .wr_y(s_axis_tdata[71:40]),
        .step_ticks(step_reg), .node_count(nodes_reg),
        .req_valid(qv), .req_pop(pop), .req(qout), .busy(back_busy),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_data(m_axis_tdata), .out_valid_res(m_axis_tuser)
    );

endmodule
